>>> design/hll_pkg.sv
// Package for the dense cardinality sketch: payload types, op codes and lane helpers.
package hll_pkg;

    localparam int DEF_MAX_PRECISION = 14;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 47;
    localparam int RECIP_SHIFT = 20;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_MERGE = 3'd1;
    localparam logic [2:0] OP_EST   = 3'd2;
    localparam logic [2:0] OP_RREG  = 3'd3;
    localparam logic [2:0] OP_RWORD = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] hash;
        logic [11:0] word_addr;
        logic [31:0] word_data;
        logic [13:0] reg_index;
    } t_in;

    typedef struct packed {
        logic [31:0] read_word;
        logic [5:0]  reg_value;
        logic [63:0] harmonic_sum;
        logic [14:0] zero_count;
    } t_out;

    function automatic logic [5:0] lane_mask(input logic [2:0] r);
        case (r)
            3'd4:    lane_mask = 6'h0f;
            3'd5:    lane_mask = 6'h1f;
            default: lane_mask = 6'h3f;
        endcase
    endfunction

    function automatic logic [3:0] lanes_per_word(input logic [2:0] r);
        case (r)
            3'd4:    lanes_per_word = 4'd8;
            3'd5:    lanes_per_word = 4'd6;
            default: lanes_per_word = 4'd5;
        endcase
    endfunction

    // register j of a word, j counted from the high end
    function automatic logic [5:0] get_lane(input logic [31:0] w, input logic [2:0] j,
                                            input logic [2:0] r);
        logic [4:0] sh;
        logic [31:0] x;
        sh = 5'((lanes_per_word(r) - 4'd1 - {1'b0, j}) * {1'b0, r});
        x = w >> sh;
        get_lane = x[5:0] & lane_mask(r);
    endfunction

    function automatic logic [31:0] lane_merge(input logic [31:0] a, input logic [31:0] b,
                                               input logic [2:0] r);
        logic [31:0] res;
        logic [31:0] m;
        res = '0;
        for (int j = 0; j < 8; j++) begin
            m = {26'd0, lane_mask(r)} << (j * int'(r));
            if (4'(j) < lanes_per_word(r)) begin
                res = res | (((a & m) < (b & m)) ? (b & m) : (a & m));
            end
        end
        lane_merge = res;
    endfunction

endpackage

>>> design/hll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/hyperloglog_dense_sketch.sv
// Top level of the dense cardinality sketch: control, arithmetic and APB registers.
// Add, merge, register and word reads pass the prepare, address, read-modify-write and
// output states before the result is valid; one item is in flight at a time.
// An estimate walks the ceil(2^p / lanes) words at one word a cycle through the
// store read port, then drains the pipeline and passes to output.
// Synchronous active-low reset sets precision 14, width 6 and then clears the store
// in a pass of one word a cycle over all words (3277 at the default depth).
module hyperloglog_dense_sketch
    import hll_pkg::*;
#(
    parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = MAX_PRECISION;
    localparam int DEPTH = ((1 << MAX_PRECISION) + 4) / 5;
    localparam int AW = $clog2(DEPTH);
    localparam int NW = MAX_PRECISION + 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_EST  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_prec;
    logic [2:0]  r_rw;
    t_in         r_in;
    t_out        r_res, n_res;
    t_out        r_out;
    logic        r_ovalid;
    logic [AW-1:0] r_clr;

    logic [4:0]  p_eff;
    logic [2:0]  rw_eff;
    logic [3:0]  per;
    logic [NW-1:0] n_regs;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {29'd0, r_rw} : {28'd0, r_prec};

    always_comb begin
        if (r_prec < 4'd4) begin
            p_eff = 5'd4;
        end else if (32'(r_prec) > MAX_PRECISION) begin
            p_eff = 5'(MAX_PRECISION);
        end else begin
            p_eff = {1'b0, r_prec};
        end
        if (r_rw < 3'd4) begin
            rw_eff = 3'd4;
        end else if (r_rw > 3'd6) begin
            rw_eff = 3'd6;
        end else begin
            rw_eff = r_rw;
        end
    end

    assign per = lanes_per_word(rw_eff);
    assign n_regs = NW'(1) << p_eff;

    // prepare stage
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  r_qe;
    logic           r_idx_ok;
    logic [7:0]     r_bnz;
    logic [2:0]     r_btz [8];
    logic [IW-1:0]  idx_c;
    logic [17:0]    rc;
    logic [IW+17:0] prod;
    logic [63:0]    v_c;
    logic [7:0]     bnz_c;
    logic [2:0]     btz_c [8];

    always_comb begin
        if (r_in.op == OP_ADD) begin
            idx_c = IW'(r_in.hash >> (7'd64 - {2'b0, p_eff}));
        end else begin
            idx_c = IW'(r_in.reg_index);
        end
        case (rw_eff)
            3'd4:    rc = 18'd131072;
            3'd5:    rc = 18'd174762;
            default: rc = 18'd209715;
        endcase
        prod = (IW+18)'(idx_c) * (IW+18)'(rc);
        v_c = r_in.hash | (64'd1 << (7'd64 - {2'b0, p_eff}));
        for (int b = 0; b < 8; b++) begin
            bnz_c[b] = v_c[8*b +: 8] != 8'd0;
            btz_c[b] = 3'd0;
            for (int t = 7; t >= 0; t--) begin
                if (v_c[8*b + t]) begin
                    btz_c[b] = 3'(t);
                end
            end
        end
    end

    // address stage
    logic [IW+3:0]  rem_raw;
    logic [IW-1:0]  q_c;
    logic [3:0]     rem_c;
    logic [6:0]     tz_c;
    logic [6:0]     rank_c;
    logic           wa_ok;
    logic [AW-1:0]  r_w;
    logic [4:0]     r_sh;
    logic [5:0]     r_rank;
    logic           r_hit;

    always_comb begin
        rem_raw = (IW+4)'(r_idx) - (IW+4)'(r_qe) * (IW+4)'(per);
        if (rem_raw >= (IW+4)'(per)) begin
            q_c = r_qe + IW'(1);
            rem_c = 4'(rem_raw - (IW+4)'(per));
        end else begin
            q_c = r_qe;
            rem_c = rem_raw[3:0];
        end
        tz_c = 7'd0;
        for (int j = 7; j >= 0; j--) begin
            if (r_bnz[j]) begin
                tz_c = 7'(8 * j) + {4'd0, r_btz[j]};
            end
        end
        rank_c = tz_c + 7'd1;
        if (rank_c > {1'b0, lane_mask(rw_eff)}) begin
            rank_c = {1'b0, lane_mask(rw_eff)};
        end
        wa_ok = (32'(r_in.word_addr) * 32'(per) < 32'(n_regs))
             && (32'(r_in.word_addr) < DEPTH);
    end

    // estimate walk
    logic [AW-1:0]  r_ea;
    logic [NW-1:0]  r_ib, r_b1;
    logic           r_v1, r_v2;
    logic [47:0]    r_t [8];
    logic [3:0]     r_zn;
    logic [63:0]    r_sum;
    logic [14:0]    r_zc;
    logic           est_issue;
    logic [50:0]    tsum;
    logic [3:0]     zn_c;
    logic [47:0]    t_c [8];

    assign est_issue = (r_state == S_EST) && (r_ib < n_regs);

    // memory
    logic           m_we, m_re;
    logic [AW-1:0]  m_waddr, m_raddr;
    logic [31:0]    m_wdata, m_rdata;
    logic [5:0]     cur_c;

    hll_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    always_comb begin
        logic [5:0] k;
        logic [31:0] x;
        zn_c = 4'd0;
        tsum = '0;
        for (int j = 0; j < 8; j++) begin
            k = get_lane(m_rdata, 3'(j), rw_eff);
            t_c[j] = '0;
            if ((4'(j) < per) && ((r_b1 + NW'(j)) < n_regs)) begin
                if (k == 6'd0) begin
                    zn_c = zn_c + 4'd1;
                end
                if (k <= 6'(FRAC_BITS)) begin
                    t_c[j] = 48'd1 << (6'(FRAC_BITS) - k);
                end
            end
            tsum = tsum + 51'(r_t[j]);
        end
        x = m_rdata >> r_sh;
        cur_c = x[5:0] & lane_mask(rw_eff);

        m_re = 1'b0;
        m_raddr = '0;
        m_we = 1'b0;
        m_waddr = r_w;
        m_wdata = '0;
        if (r_state == S_CLR) begin
            m_we = 1'b1;
            m_waddr = r_clr;
        end else if (r_state == S_ADDR) begin
            m_re = 1'b1;
            m_raddr = (r_in.op == OP_MERGE || r_in.op == OP_RWORD)
                    ? AW'(r_in.word_addr) : q_c[AW-1:0];
        end else if (est_issue) begin
            m_re = 1'b1;
            m_raddr = r_ea;
        end else if (r_state == S_MOD && r_hit) begin
            if (r_in.op == OP_ADD && cur_c < r_rank) begin
                m_we = 1'b1;
                m_wdata = (m_rdata & ~({26'd0, lane_mask(rw_eff)} << r_sh))
                        | ({26'd0, r_rank} << r_sh);
            end else if (r_in.op == OP_MERGE) begin
                m_we = 1'b1;
                m_wdata = lane_merge(m_rdata, r_in.word_data, rw_eff);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_res = r_res;
        case (r_state)
            S_CLR: begin
                if (32'(r_clr) == DEPTH - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res = '0;
                    case (i_in_data.op)
                        OP_ADD, OP_MERGE, OP_RREG, OP_RWORD: n_state = S_PREP;
                        OP_EST:  n_state = S_EST;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_PREP:  n_state = S_ADDR;
            S_ADDR:  n_state = S_MOD;
            S_MOD: begin
                if (r_in.op == OP_RREG && r_hit) begin
                    n_res.reg_value = cur_c;
                end
                if (r_in.op == OP_RWORD && r_hit) begin
                    n_res.read_word = m_rdata;
                end
                n_state = S_OUT;
            end
            S_EST: begin
                if (!est_issue && !r_v1 && !r_v2) begin
                    n_res.harmonic_sum = r_sum;
                    n_res.zero_count = r_zc;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_prec <= 4'd14;
            r_rw <= 3'd6;
            r_ovalid <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res <= n_res;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (psel && penable && pwrite) begin
                if (paddr[2]) begin
                    r_rw <= pwdata[2:0];
                end else begin
                    r_prec <= pwdata[3:0];
                end
            end
            if (r_state == S_IDLE && i_in_valid) begin
                r_in <= i_in_data;
                r_ea <= '0;
                r_ib <= '0;
                r_sum <= '0;
                r_zc <= '0;
            end
            if (r_state == S_PREP) begin
                r_idx <= idx_c;
                r_qe <= IW'(prod >> RECIP_SHIFT);
                r_idx_ok <= 32'(r_in.reg_index) < 32'(n_regs);
                r_bnz <= bnz_c;
                r_btz <= btz_c;
            end
            if (r_state == S_ADDR) begin
                r_w <= (r_in.op == OP_MERGE || r_in.op == OP_RWORD)
                     ? AW'(r_in.word_addr) : q_c[AW-1:0];
                r_sh <= 5'((per - 4'd1 - rem_c) * {1'b0, rw_eff});
                r_rank <= rank_c[5:0];
                case (r_in.op)
                    OP_ADD:  r_hit <= 1'b1;
                    OP_RREG: r_hit <= r_idx_ok;
                    default: r_hit <= wa_ok;
                endcase
            end
            r_v1 <= est_issue;
            if (est_issue) begin
                r_ea <= r_ea + AW'(1);
                r_ib <= r_ib + NW'(per);
                r_b1 <= r_ib;
            end
            r_v2 <= r_v1;
            if (r_v1) begin
                r_t <= t_c;
                r_zn <= zn_c;
            end
            if (r_v2) begin
                r_sum <= r_sum + 64'(tsum);
                r_zc <= r_zc + 15'(r_zn);
            end
            if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
                r_out <= r_res;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule

>>> design/hll_checker.sv
// Port-level checker for the dense cardinality sketch, bound to the top level.
module hll_checker
    import hll_pkg::*;
#(
    parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data,
    input logic pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_count != 15'd0
        |-> o_out_data.harmonic_sum >= (64'd1 << FRAC_BITS))
        else $error("zero registers missing from sum");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.read_word != 32'd0 && o_out_data.harmonic_sum != 64'd0)
                     && !(o_out_data.reg_value != 6'd0 && o_out_data.harmonic_sum != 64'd0)
                     && (32'(o_out_data.zero_count) <= (1 << MAX_PRECISION)))
        else $error("inconsistent result fields");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind hyperloglog_dense_sketch hll_checker #(.MAX_PRECISION(MAX_PRECISION)) u_hll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
